FILE: sv/epb_pkg.sv
// Shared types, constants, preset poses and the control program of the eyelid pose blender.
package epb_pkg;

   localparam int POSE_N = 12;

   localparam logic [15:0] FRAC_ONE   = 16'd32768;
   localparam logic [15:0] STEP_RESET = 16'd1638;

   typedef logic [3:0] pose_idx_type;
   typedef logic [3:0] upc_type;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_EMOTION = 2'd1,
      OP_CLOSE   = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      EMO_NONE    = 2'd0,
      EMO_NORMAL  = 2'd1,
      EMO_SHY     = 2'd2,
      EMO_UNKNOWN = 2'd3
   } emotion_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] close_value;
      logic [1:0]  emotion_code;
   } req_type;

   typedef struct packed {
      logic signed [15:0] upper_angle;
      logic signed [15:0] upper_x;
      logic signed [15:0] upper_y;
      logic signed [15:0] lower_angle;
      logic signed [15:0] lower_x;
      logic signed [15:0] lower_y;
   } rsp_type;

   // Operands handed to the blend unit: result = a + (b - a) * f, rounded.
   typedef struct packed {
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic [15:0]        f;
   } mix_op_type;

   // Preset poses, indexed by emotion code and then lid*6 + pose*3 + item.
   localparam logic signed [15:0] PRESET [3][POSE_N] = '{
      '{16'sd0, 16'sd0, 16'sd512, 16'sd0, 16'sd0, 16'sd512,
        16'sd0, 16'sd0, -16'sd512, 16'sd0, 16'sd0, -16'sd512},
      '{16'sd0, 16'sd0, 16'sd384, 16'sd0, 16'sd0, 16'sd128,
        16'sd0, 16'sd0, -16'sd410, 16'sd0, 16'sd0, -16'sd384},
      '{-16'sd2560, 16'sd0, 16'sd307, 16'sd0, 16'sd0, 16'sd128,
        16'sd0, 16'sd0, -16'sd410, 16'sd0, 16'sd0, -16'sd384}
   };

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_PROGRESS,
      ACT_ISSUE_BLEND,
      ACT_WB_POSE,
      ACT_LOAD_A,
      ACT_ISSUE_CLOSE,
      ACT_WB_OUT,
      ACT_PUSH
   } act_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_SETTLED,
      COND_MORE_POSE,
      COND_MORE_OUT,
      COND_RSP_BLOCKED
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      upc_type  target;
   } ucode_type;

   localparam upc_type UPC_PROGRESS = 4'd0;
   localparam upc_type UPC_BLEND    = 4'd1;
   localparam upc_type UPC_CLOSE    = 4'd4;
   localparam upc_type UPC_PUSH     = 4'd8;

   // Control program for one frame tick. A jump is taken when its condition holds.
   function automatic ucode_type ucode_rom(upc_type upc);
      ucode_type uw;
      case (upc)
         4'd0:    uw = '{act: ACT_PROGRESS,    cond: COND_SETTLED,     target: UPC_CLOSE};
         4'd1:    uw = '{act: ACT_ISSUE_BLEND, cond: COND_NEVER,       target: UPC_PROGRESS};
         4'd2:    uw = '{act: ACT_NONE,        cond: COND_NEVER,       target: UPC_PROGRESS};
         4'd3:    uw = '{act: ACT_WB_POSE,     cond: COND_MORE_POSE,   target: UPC_BLEND};
         4'd4:    uw = '{act: ACT_LOAD_A,      cond: COND_NEVER,       target: UPC_PROGRESS};
         4'd5:    uw = '{act: ACT_ISSUE_CLOSE, cond: COND_NEVER,       target: UPC_PROGRESS};
         4'd6:    uw = '{act: ACT_NONE,        cond: COND_NEVER,       target: UPC_PROGRESS};
         4'd7:    uw = '{act: ACT_WB_OUT,      cond: COND_MORE_OUT,    target: UPC_CLOSE};
         4'd8:    uw = '{act: ACT_PUSH,        cond: COND_RSP_BLOCKED, target: UPC_PUSH};
         default: uw = '{act: ACT_NONE,        cond: COND_NEVER,       target: UPC_PROGRESS};
      endcase
      return uw;
   endfunction

endpackage

FILE: sv/epb_mix.sv
// Two-stage pipelined blend unit: a + round((b - a) * f / 32768).
module epb_mix (
   input  logic                clock,
   input  logic                load,
   input  epb_pkg::mix_op_type op,
   output logic signed [15:0]  result
);

   localparam logic signed [33:0] ROUND_HALF = 34'sd16384;

   logic signed [15:0] a_s1_ff;
   logic signed [16:0] diff_s1_ff;
   logic [15:0]        f_s1_ff;
   logic signed [15:0] a_s2_ff;
   logic signed [33:0] prod_s2_ff;
   logic signed [33:0] rounded;

   always_ff @(posedge clock) begin
      if (load) begin
         a_s1_ff    <= op.a;
         diff_s1_ff <= {op.b[15], op.b} - {op.a[15], op.a};
         f_s1_ff    <= op.f;
      end
      a_s2_ff    <= a_s1_ff;
      prod_s2_ff <= diff_s1_ff * $signed({1'b0, f_s1_ff});
   end

   // The blend is convex, so the low 16 bits of the sum are the whole answer.
   assign rounded = prod_s2_ff + ROUND_HALF;
   assign result  = a_s2_ff + rounded[30:15];

endmodule

FILE: sv/eyelid_pose_blender.sv
// Eyelid pose blender: emotion transitions and close blend of two eyelid poses.
// Emotion and close-fraction commands take effect in the cycle they are accepted.
// A frame tick with work pending runs a microcoded program: twelve pose blends and six
// close blends while a transition is in progress, only the six close blends once it has settled.
// One shared two-stage blend unit does all of them; ticks are taken one at a time.
// Synchronous reset loads the normal preset everywhere, clears progress and close fraction.
module eyelid_pose_blender (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  epb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output epb_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data
);

   // Pose indexes: the closed pose sits three entries after its open pose, and the
   // open items of the two lids are indexes 0 to 2 and 6 to 8.
   localparam epb_pkg::pose_idx_type CLOSED_OFS      = 4'd3;
   localparam epb_pkg::pose_idx_type LAST_POSE       = 4'(epb_pkg::POSE_N - 1);
   localparam epb_pkg::pose_idx_type UPPER_LAST_OPEN = 4'd2;
   localparam epb_pkg::pose_idx_type LOWER_FIRST_OPEN = 4'd6;
   localparam epb_pkg::pose_idx_type LOWER_LAST_OPEN = 4'd8;

   // Pose state and transition control.
   logic signed [15:0] cur_ff [epb_pkg::POSE_N];
   logic signed [15:0] old_ff [epb_pkg::POSE_N];
   logic signed [15:0] tgt_ff [epb_pkg::POSE_N];
   logic [15:0]        progress_ff;
   logic [15:0]        close_ff;
   logic               pending_ff;
   logic [1:0]         emotion_ff;
   logic [15:0]        step_ff;

   // Sequencer.
   logic                  busy_ff;
   epb_pkg::upc_type      upc_ff;
   epb_pkg::upc_type      upc_in;
   epb_pkg::pose_idx_type idx_ff;
   epb_pkg::ucode_type    uw;
   logic                  cond_hit;

   // Datapath around the shared blend unit.
   logic signed [15:0]    a_hold_ff;
   logic signed [15:0]    res_ff [6];
   epb_pkg::pose_idx_type rd_addr;
   logic signed [15:0]    cur_rd;
   epb_pkg::mix_op_type   mix_op;
   logic                  mix_load;
   logic signed [15:0]    mix_result;
   logic [2:0]            out_slot;
   logic [16:0]           progress_sum;
   logic [15:0]           close_sat;

   logic             rsp_valid_ff;
   epb_pkg::rsp_type rsp_data_ff;

   logic req_accept;
   logic push_now;

   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign uw = epb_pkg::ucode_rom(upc_ff);

   always_comb begin
      case (uw.cond)
         epb_pkg::COND_NEVER:       cond_hit = 1'b0;
         epb_pkg::COND_SETTLED:     cond_hit = progress_ff >= epb_pkg::FRAC_ONE;
         epb_pkg::COND_MORE_POSE:   cond_hit = idx_ff != LAST_POSE;
         epb_pkg::COND_MORE_OUT:    cond_hit = idx_ff != LOWER_LAST_OPEN;
         epb_pkg::COND_RSP_BLOCKED: cond_hit = rsp_valid_ff && rsp_stall;
         default:                   cond_hit = 1'b0;
      endcase
      upc_in = cond_hit ? uw.target : upc_ff + 4'd1;
   end

   // The output register takes the new item once it is empty or being emptied.
   assign push_now = busy_ff && (uw.act == epb_pkg::ACT_PUSH) && !cond_hit;

   // The current pose array has one read port; the close step reads the closed pose.
   assign rd_addr = (uw.act == epb_pkg::ACT_ISSUE_CLOSE) ? idx_ff + CLOSED_OFS : idx_ff;
   assign cur_rd  = cur_ff[rd_addr];

   always_comb begin
      mix_load = 1'b0;
      mix_op   = '{a: a_hold_ff, b: cur_rd, f: close_ff};
      if (busy_ff && uw.act == epb_pkg::ACT_ISSUE_BLEND) begin
         mix_load = 1'b1;
         mix_op   = '{a: old_ff[idx_ff], b: tgt_ff[idx_ff], f: progress_ff};
      end else if (busy_ff && uw.act == epb_pkg::ACT_ISSUE_CLOSE) begin
         mix_load = 1'b1;
      end
   end

   epb_mix u_mix (
      .clock  (clock),
      .load   (mix_load),
      .op     (mix_op),
      .result (mix_result)
   );

   assign out_slot     = (idx_ff < LOWER_FIRST_OPEN) ? idx_ff[2:0] : 3'(idx_ff - CLOSED_OFS);
   assign progress_sum = {1'b0, progress_ff} + {1'b0, step_ff};
   assign close_sat    = (req_data.close_value > epb_pkg::FRAC_ONE) ? epb_pkg::FRAC_ONE
                                                                    : req_data.close_value;

   // Control and pose state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < epb_pkg::POSE_N; i++) begin
            cur_ff[i] <= epb_pkg::PRESET[epb_pkg::EMO_NORMAL][i];
            old_ff[i] <= epb_pkg::PRESET[epb_pkg::EMO_NORMAL][i];
            tgt_ff[i] <= epb_pkg::PRESET[epb_pkg::EMO_NORMAL][i];
         end
         progress_ff  <= '0;
         close_ff     <= '0;
         pending_ff   <= 1'b1;
         emotion_ff   <= epb_pkg::EMO_NORMAL;
         step_ff      <= epb_pkg::STEP_RESET;
         busy_ff      <= 1'b0;
         upc_ff       <= epb_pkg::UPC_PROGRESS;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            step_ff <= csr_wr_data;
         end

         // A departing item is replaced in the same cycle when the program pushes.
         if (rsp_valid_ff && !rsp_stall && !push_now) begin
            rsp_valid_ff <= 1'b0;
         end

         if (req_accept) begin
            case (req_data.opcode)
               epb_pkg::OP_TICK: begin
                  // A tick with nothing pending is consumed without a result.
                  if (pending_ff) begin
                     busy_ff <= 1'b1;
                     upc_ff  <= epb_pkg::UPC_PROGRESS;
                     idx_ff  <= '0;
                  end
               end
               epb_pkg::OP_EMOTION: begin
                  if (req_data.emotion_code != emotion_ff) begin
                     emotion_ff <= req_data.emotion_code;
                     for (int i = 0; i < epb_pkg::POSE_N; i++) begin
                        old_ff[i] <= cur_ff[i];
                        if (req_data.emotion_code != epb_pkg::EMO_UNKNOWN) begin
                           tgt_ff[i] <= epb_pkg::PRESET[req_data.emotion_code][i];
                        end
                     end
                     progress_ff <= '0;
                     pending_ff  <= 1'b1;
                  end
               end
               epb_pkg::OP_CLOSE: begin
                  if (close_sat != close_ff) begin
                     close_ff   <= close_sat;
                     pending_ff <= 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end

         if (busy_ff) begin
            upc_ff <= upc_in;
            case (uw.act)
               epb_pkg::ACT_PROGRESS: begin
                  idx_ff <= '0;
                  if (progress_ff < epb_pkg::FRAC_ONE) begin
                     progress_ff <= (progress_sum > {1'b0, epb_pkg::FRAC_ONE})
                                    ? epb_pkg::FRAC_ONE : progress_sum[15:0];
                  end
               end
               epb_pkg::ACT_WB_POSE: begin
                  cur_ff[idx_ff] <= mix_result;
                  idx_ff         <= cond_hit ? idx_ff + 4'd1 : '0;
               end
               epb_pkg::ACT_WB_OUT: begin
                  idx_ff <= (idx_ff == UPPER_LAST_OPEN) ? LOWER_FIRST_OPEN : idx_ff + 4'd1;
               end
               epb_pkg::ACT_PUSH: begin
                  // The next accepted tick restarts the program counter.
                  if (push_now) begin
                     rsp_valid_ff <= 1'b1;
                     busy_ff      <= 1'b0;
                     if (progress_ff >= epb_pkg::FRAC_ONE) begin
                        pending_ff <= 1'b0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      if (busy_ff && uw.act == epb_pkg::ACT_LOAD_A) begin
         a_hold_ff <= cur_rd;
      end
      if (busy_ff && uw.act == epb_pkg::ACT_WB_OUT) begin
         res_ff[out_slot] <= mix_result;
      end
      if (push_now) begin
         rsp_data_ff <= '{upper_angle: res_ff[0], upper_x: res_ff[1], upper_y: res_ff[2],
                          lower_angle: res_ff[3], lower_x: res_ff[4], lower_y: res_ff[5]};
      end
   end

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the eyelid pose blender: random commands, step settings, field checks.
`timescale 1ns / 100ps

module tb_top;

   // The two-bit opcode field has one code that the block defines no action for.
   localparam logic [1:0] OP_SPARE = 2'd3;

   // The settle pause outlasts a frame tick with a transition running, so it is enough
   // for the block to finish any tick that produced no result before a register write.
   localparam int SETTLE_CYCLES = 70;

   // Longest legal stretch with no handshake: a frame tick with a transition running, a response
   // stall burst, a sender gap and the settle pause. The limit is several times that.
   localparam int QUIET_LIMIT = 3000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   epb_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   epb_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [15:0]      csr_wr_data = '0;

   eyelid_pose_blender dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Commands waiting for the driver, and lid poses that the block still owes us.
   epb_pkg::req_type cmd_backlog [$];
   epb_pkg::rsp_type lid_pose_due [$];

   // Our own copy of the blender state, kept in step with every accepted item.
   logic signed [15:0]   pose_now  [epb_pkg::POSE_N];
   logic signed [15:0]   pose_from [epb_pkg::POSE_N];
   logic signed [15:0]   pose_goal [epb_pkg::POSE_N];
   int unsigned          ramp;
   logic [15:0]          close_frac;
   logic                 lids_busy;
   epb_pkg::emotion_type mood;
   logic [15:0]          ramp_step;

   // When set, neither side inserts idle cycles; used for the closing part of the run.
   logic calm = 1'b0;

   int req_gap;
   int hold_left;
   int quiet_cycles;
   int items_queued;
   int items_taken;
   int poses_checked;
   int field_errors;
   int step_settings;

   string lid_field_name [6] = '{"upper_angle", "upper_x", "upper_y",
                                 "lower_angle", "lower_x", "lower_y"};

   // Q1.15 weighted mix of two Q8.8 values, rounded half up with a floor shift.
   function automatic logic signed [15:0] mix_q15(input logic signed [15:0] a,
                                                  input logic signed [15:0] b,
                                                  input logic [15:0] f);
      longint acc;
      acc = longint'(a) * (longint'(epb_pkg::FRAC_ONE) - longint'(f))
            + longint'(b) * longint'(f) + 64'sd16384;
      return 16'(acc >>> 15);
   endfunction

   // Applies one accepted command to the shadow state. A frame tick with work pending
   // queues the lid pose that the block has to deliver for it.
   task automatic advance_lids(input epb_pkg::req_type cmd);
      logic [15:0]        cv;
      logic signed [15:0] lid [6];
      case (cmd.opcode)
         epb_pkg::OP_CLOSE: begin
            // Values above one are clipped before the comparison with the held fraction.
            cv = (cmd.close_value > epb_pkg::FRAC_ONE) ? epb_pkg::FRAC_ONE : cmd.close_value;
            if (cv != close_frac) begin
               close_frac = cv;
               lids_busy  = 1'b1;
            end
         end
         epb_pkg::OP_EMOTION: begin
            // Asking again for the active emotion changes nothing at all.
            if (cmd.emotion_code != mood) begin
               mood      = epb_pkg::emotion_type'(cmd.emotion_code);
               pose_from = pose_now;
               // An unknown emotion restarts the transition toward the previous target.
               if (cmd.emotion_code != epb_pkg::EMO_UNKNOWN)
                  pose_goal = epb_pkg::PRESET[cmd.emotion_code];
               ramp      = 0;
               lids_busy = 1'b1;
            end
         end
         epb_pkg::OP_TICK: begin
            if (lids_busy) begin
               if (ramp < epb_pkg::FRAC_ONE) begin
                  ramp = ramp + ramp_step;
                  if (ramp > epb_pkg::FRAC_ONE)
                     ramp = epb_pkg::FRAC_ONE;
                  for (int k = 0; k < epb_pkg::POSE_N; k++)
                     pose_now[k] = mix_q15(pose_from[k], pose_goal[k], 16'(ramp));
               end
               // Each lid sits between its open and closed pose by the close fraction.
               for (int s = 0; s < 2; s++)
                  for (int k = 0; k < 3; k++)
                     lid[s*3 + k] = mix_q15(pose_now[s*6 + k], pose_now[s*6 + 3 + k],
                                            close_frac);
               lid_pose_due.push_back(epb_pkg::rsp_type'{lid[0], lid[1], lid[2],
                                                         lid[3], lid[4], lid[5]});
               if (ramp >= epb_pkg::FRAC_ONE)
                  lids_busy = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   // Driver: presents backlog commands one at a time and holds each one while stalled.
   // After an accepted item it sometimes goes quiet for a burst of cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         req_gap    = 0;
         pose_now   = epb_pkg::PRESET[epb_pkg::EMO_NORMAL];
         pose_from  = epb_pkg::PRESET[epb_pkg::EMO_NORMAL];
         pose_goal  = epb_pkg::PRESET[epb_pkg::EMO_NORMAL];
         ramp       = 0;
         close_frac = '0;
         lids_busy  = 1'b1;
         mood       = epb_pkg::EMO_NORMAL;
         ramp_step  = epb_pkg::STEP_RESET;
      end else begin
         if (req_valid && !req_stall) begin
            advance_lids(req_data);
            items_taken++;
            if (!calm && $urandom_range(0, 3) == 0)
               req_gap = $urandom_range(1, 14);
         end
         // A new item may only be presented once the current one is gone.
         if (!req_valid || !req_stall) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= cmd_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every accepted lid pose against the oldest one we expect, and
   // stalls the result side in random bursts.
   always @(posedge clock) begin
      epb_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (lid_pose_due.size() == 0) begin
               field_errors++;
               if (field_errors <= 10)
                  $display("[%0t] lid pose %h arrived with none outstanding", $realtime,
                           rsp_data);
            end else begin
               want = lid_pose_due.pop_front();
               poses_checked++;
               for (int i = 0; i < 6; i++) begin
                  if (rsp_data[95 - 16*i -: 16] !== want[95 - 16*i -: 16]) begin
                     field_errors++;
                     if (field_errors <= 10)
                        $display("[%0t] pose %0d %s: expected %0d, got %0d", $realtime,
                                 poses_checked, lid_field_name[i],
                                 $signed(want[95 - 16*i -: 16]),
                                 $signed(rsp_data[95 - 16*i -: 16]));
                  end
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            hold_left = $urandom_range(0, 13);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: a run that goes too long without any handshake has hung.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles, %0d poses still owed", $realtime,
                     QUIET_LIMIT, lid_pose_due.size());
            $display("eyelid_pose_blender: mismatch");
            $finish;
         end
      end
   end

   task automatic queue_cmd(input logic [1:0] op, input logic [15:0] cv,
                            input logic [1:0] emo);
      cmd_backlog.push_back(epb_pkg::req_type'{opcode: op, close_value: cv,
                                               emotion_code: emo});
      items_queued++;
   endtask

   // Close values lean on the ends of the range and on values that must be clipped.
   function automatic logic [15:0] pick_close();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return epb_pkg::FRAC_ONE;
         2:       return 16'($urandom_range(32769, 65535));
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   // Waits until the block has taken every command and delivered every pose, then
   // lets it finish any tick that had nothing to deliver.
   task automatic settle();
      do @(posedge clock);
      while (cmd_backlog.size() != 0 || req_valid || lid_pose_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_step(input logic [15:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ramp_step = value;
      step_settings++;
   endtask

   // Mostly well-formed transitions: an emotion change followed by frame ticks, enough to run
   // it out unless the step is small or zero, with close changes mixed in. The rest is arbitrary commands.
   task automatic stir_moods(input int budget);
      int start;
      int ticks;
      start = items_queued;
      while (items_queued - start < budget) begin
         if ($urandom_range(0, 9) < 7) begin
            queue_cmd(epb_pkg::OP_EMOTION, 16'($urandom), 2'($urandom_range(0, 3)));
            if (ramp_step == 0)
               ticks = $urandom_range(3, 8);
            else
               ticks = (32768 + ramp_step - 1) / ramp_step + $urandom_range(0, 2);
            if (ticks > 24)
               ticks = 24;
            for (int j = 0; j < ticks; j++) begin
               if ($urandom_range(0, 6) == 0)
                  queue_cmd(epb_pkg::OP_CLOSE, pick_close(), 2'($urandom));
               queue_cmd(epb_pkg::OP_TICK, 16'($urandom), 2'($urandom));
            end
         end else begin
            repeat ($urandom_range(1, 4))
               queue_cmd(2'($urandom_range(0, 3)), pick_close(), 2'($urandom_range(0, 3)));
         end
      end
   endtask

   initial begin
      items_queued  = 0;
      items_taken   = 0;
      poses_checked = 0;
      field_errors  = 0;
      step_settings = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed opening at the reset step: the initial pending tick, close extremes and a
      // clipped close, a repeated emotion, unknown and none emotions, the spare opcode.
      queue_cmd(epb_pkg::OP_TICK, '0, '0);
      queue_cmd(epb_pkg::OP_CLOSE, epb_pkg::FRAC_ONE, epb_pkg::EMO_NONE);
      queue_cmd(epb_pkg::OP_CLOSE, 16'hFFFF, epb_pkg::EMO_UNKNOWN);
      queue_cmd(epb_pkg::OP_TICK, '1, '1);
      queue_cmd(epb_pkg::OP_EMOTION, '0, epb_pkg::EMO_SHY);
      queue_cmd(epb_pkg::OP_EMOTION, '1, epb_pkg::EMO_SHY);
      queue_cmd(epb_pkg::OP_TICK, '0, '0);
      queue_cmd(epb_pkg::OP_CLOSE, '0, epb_pkg::EMO_NORMAL);
      queue_cmd(epb_pkg::OP_TICK, '0, '0);
      queue_cmd(epb_pkg::OP_TICK, '0, '0);
      queue_cmd(epb_pkg::OP_EMOTION, '0, epb_pkg::EMO_UNKNOWN);
      queue_cmd(epb_pkg::OP_TICK, '0, '0);
      queue_cmd(epb_pkg::OP_EMOTION, '0, epb_pkg::EMO_NONE);
      queue_cmd(epb_pkg::OP_TICK, '0, '0);
      queue_cmd(OP_SPARE, 16'h5A5A, epb_pkg::EMO_SHY);
      queue_cmd(epb_pkg::OP_CLOSE, 16'd16384, epb_pkg::EMO_NONE);
      queue_cmd(epb_pkg::OP_TICK, '0, '0);
      queue_cmd(epb_pkg::OP_CLOSE, 16'd1, epb_pkg::EMO_NONE);
      queue_cmd(epb_pkg::OP_TICK, '0, '0);
      queue_cmd(epb_pkg::OP_EMOTION, '0, epb_pkg::EMO_NORMAL);
      queue_cmd(epb_pkg::OP_TICK, '0, '0);
      queue_cmd(epb_pkg::OP_TICK, '0, '0);

      // Step extremes: a full step finishes in one tick, a zero step never finishes,
      // the smallest step crawls, and an oversized step saturates progress at once.
      program_step(epb_pkg::FRAC_ONE);
      stir_moods(40);
      program_step(16'd0);
      stir_moods(30);
      program_step(16'd1);
      stir_moods(30);
      program_step(16'hFFFF);
      stir_moods(30);

      repeat (3) begin
         if ($urandom_range(0, 3) == 0)
            program_step(16'($urandom_range(1, 1000)));
         else
            program_step(16'($urandom_range(1001, 32768)));
         stir_moods(60);
      end

      // Closing stretch at full rate on both sides.
      program_step(16'($urandom_range(1001, 32768)));
      calm = 1'b1;
      stir_moods(60);

      settle();
      if (lid_pose_due.size() != 0) begin
         field_errors += lid_pose_due.size();
         $display("%0d lid poses never arrived", lid_pose_due.size());
      end
      $display("Drove %0d commands (ticks, emotion and close changes, spare opcodes)",
               items_taken);
      $display("under %0d step settings; %0d lid poses compared, %0d field errors.",
               step_settings, poses_checked, field_errors);
      if (field_errors == 0)
         $display("eyelid_pose_blender: match");
      else
         $display("eyelid_pose_blender: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
sv/epb_pkg.sv
sv/epb_mix.sv
sv/eyelid_pose_blender.sv
bench/tb_top.sv
